// ===== hw/rtl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the periodic timer scheduler
// Opcodes, status codes, payload structs and sequencer states.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int MAX_TIMERS_DEF = 16;
   localparam int ID_BITS_DEF    = 8;
   localparam int TIME_BITS_DEF  = 32;

   localparam logic [2:0] OP_ADD     = 3'd0;
   localparam logic [2:0] OP_REMOVE  = 3'd1;
   localparam logic [2:0] OP_RUN     = 3'd2;
   localparam logic [2:0] OP_UPDATE  = 3'd3;
   localparam logic [2:0] OP_SERVICE = 3'd4;
   localparam logic [2:0] OP_QUERY   = 3'd5;
   localparam logic [2:0] OP_CLEAR   = 3'd6;
   localparam logic [2:0] OP_UNUSED  = 3'd7;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_PER  = 3'd1;
   localparam logic [2:0] ST_DUP      = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  timer_id;
      logic [31:0] period;
      logic [31:0] first_delay;
      logic        restart;
      logic [31:0] now_time;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  fired_id;
      logic [31:0] fire_time;
      logic [2:0]  status;
      logic        is_registered;
      logic [4:0]  active_count;
      logic        due_pending;
      logic [4:0]  fired_count;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIND,
      S_DECIDE,
      S_TAKE,
      S_INS_SCAN,
      S_INS_SHIFT,
      S_SVC_CHECK,
      S_FIRE_OUT,
      S_STAT_FIND,
      S_STAT_OUT
   } state_type;

endpackage

// ===== hw/rtl/periodic_timer_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_scheduler: sorted queue of periodic timers
// A table sorted by next fire time (ties by lower id) is walked one entry a
// cycle by a single compare unit under a small sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  req_    | in        | req_valid/stall  | req_type (opcode, id, times)
//  rsp_    | out       | rsp_valid/stall  | rsp_type (fire and status records)
//
// Every table walk moves one entry a cycle; add, remove, run now, update and
// query use the walks they need (search, take-out, ordered insert, status
// search). Service takes out, fires and reinserts each due timer and stops
// after MAX_TIMERS fires.
// Reset clears the count and the sequencer; the table contents are undefined.
// A stalled response holds the sequencer in place until its transfer.
// ----------------------------------------------------------------------------
module periodic_timer_scheduler
   import pts_pkg::*;
#(
   parameter int MAX_TIMERS = MAX_TIMERS_DEF,
   parameter int ID_BITS    = ID_BITS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_BITS = $clog2(MAX_TIMERS);
   localparam int CNT_BITS = $clog2(MAX_TIMERS + 1);
   localparam int FC_BITS  = $clog2(MAX_TIMERS + 1);
   // Periods arrive as 32-bit values and are kept whole, so the adder is at
   // least that wide and saturates against the largest time value.
   localparam int OPW = (TIME_BITS > 32) ? TIME_BITS : 32;
   localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};
   localparam logic [OPW:0] SAT_LIM = {{(OPW + 1 - TIME_BITS){1'b0}}, TMAX};

   // Table storage; only the first count_ff entries are meaningful.
   logic [ID_BITS-1:0]   tab_id   [MAX_TIMERS];
   logic [OPW-1:0]       tab_per  [MAX_TIMERS];
   logic [TIME_BITS-1:0] tab_next [MAX_TIMERS];

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [CNT_BITS-1:0]  ptr_ff, ptr_in;       // walking position
   logic [CNT_BITS-1:0]  pos_ff, pos_in;       // found or insert position
   logic                 found_ff, found_in;
   logic [FC_BITS-1:0]   fired_ff, fired_in;
   logic [2:0]           status_ff, status_in;
   logic [2:0]           op_ff;
   logic [ID_BITS-1:0]   id_ff;                // id of the request
   logic [31:0]          per_in_ff, fd_ff;
   logic                 rst_ff;
   logic [TIME_BITS-1:0] now_ff;
   // The entry that is on its way back into the table.
   logic [ID_BITS-1:0]   ins_id_ff, ins_id_in;
   logic [OPW-1:0]       ins_per_ff, ins_per_in;
   logic [TIME_BITS-1:0] ins_next_ff, ins_next_in;
   logic                 after_ins_svc_ff, after_ins_svc_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Shared saturating adder: now plus operand.
   logic [OPW-1:0]       add_b;
   logic [OPW:0]         add_sum;
   logic [TIME_BITS-1:0] add_sat;
   assign add_sum = {1'b0, OPW'(now_ff)} + {1'b0, add_b};
   assign add_sat = (add_sum > SAT_LIM) ? TMAX : add_sum[TIME_BITS-1:0];

   logic [IDX_BITS-1:0] pidx, pidx_m1;
   assign pidx    = ptr_ff[IDX_BITS-1:0];
   assign pidx_m1 = IDX_BITS'(ptr_ff - CNT_BITS'(1));

   logic [OPW-1:0] per_w, fd_w;
   assign per_w = OPW'(per_in_ff);
   assign fd_w  = OPW'(fd_ff);

   logic accept;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_data.opcode;
         id_ff     <= ID_BITS'(req_data.timer_id);
         per_in_ff <= req_data.period;
         fd_ff     <= req_data.first_delay;
         rst_ff    <= req_data.restart;
         now_ff    <= TIME_BITS'(req_data.now_time);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:      if (accept) state_in = S_FIND;
         S_FIND:      if (ptr_ff >= count_ff || tab_id[pidx] == id_ff) state_in = S_DECIDE;
         S_DECIDE:    state_in = S_STAT_FIND;
         S_TAKE:      if (ptr_ff + CNT_BITS'(1) >= count_ff) state_in = S_INS_SCAN;
         S_INS_SCAN:  if (ptr_ff >= count_ff || ins_next_ff < tab_next[pidx] ||
                         (ins_next_ff == tab_next[pidx] && ins_id_ff < tab_id[pidx]))
                         state_in = S_INS_SHIFT;
         S_INS_SHIFT: if (ptr_ff == pos_ff) state_in = after_ins_svc_ff ? S_SVC_CHECK
                                                                       : S_STAT_FIND;
         S_SVC_CHECK: state_in = S_STAT_FIND;
         S_FIRE_OUT:  if (!rsp_valid_ff || !rsp_stall) state_in = S_TAKE;
         S_STAT_FIND: if (ptr_ff >= count_ff || tab_id[pidx] == id_ff) state_in = S_STAT_OUT;
         S_STAT_OUT:  if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
      // Decisions that branch elsewhere are refined below.
      if (state_ff == S_DECIDE) begin
         case (op_ff)
            OP_ADD:
               if (per_in_ff != 32'd0 && !found_ff && count_ff < CNT_BITS'(MAX_TIMERS))
                  state_in = fd_ff[31] ? S_FIRE_OUT : S_INS_SCAN;
            OP_REMOVE:  if (found_ff) state_in = S_TAKE;
            OP_RUN:     if (found_ff) state_in = S_FIRE_OUT;
            OP_UPDATE:  if (per_in_ff != 32'd0 && found_ff) state_in = S_TAKE;
            OP_SERVICE: state_in = S_SVC_CHECK;
            default:    state_in = S_STAT_FIND;
         endcase
      end
      if (state_ff == S_SVC_CHECK && fired_ff < FC_BITS'(MAX_TIMERS) &&
          count_ff != '0 && tab_next[0] <= now_ff)
         state_in = S_FIRE_OUT;
      if (state_ff == S_TAKE && ptr_ff + CNT_BITS'(1) >= count_ff && op_ff == OP_REMOVE)
         state_in = S_STAT_FIND;
      if (state_ff == S_FIRE_OUT && op_ff == OP_ADD && (!rsp_valid_ff || !rsp_stall))
         state_in = S_INS_SCAN;
   end

   // Datapath controls.
   always_comb begin
      count_in         = count_ff;
      ptr_in           = ptr_ff;
      pos_in           = pos_ff;
      found_in         = found_ff;
      fired_in         = fired_ff;
      status_in        = status_ff;
      ins_id_in        = ins_id_ff;
      ins_per_in       = ins_per_ff;
      ins_next_in      = ins_next_ff;
      after_ins_svc_in = after_ins_svc_ff;
      rsp_in           = rsp_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      add_b            = per_w;
      case (state_ff)
         S_IDLE: begin
            ptr_in = '0; found_in = 1'b0; fired_in = '0; status_in = ST_OK;
            after_ins_svc_in = 1'b0;
         end
         S_FIND: begin
            if (ptr_ff < count_ff && tab_id[pidx] == id_ff) begin
               found_in = 1'b1; pos_in = ptr_ff;
            end else if (ptr_ff < count_ff) begin
               ptr_in = ptr_ff + CNT_BITS'(1);
            end
         end
         S_DECIDE: begin
            ptr_in = pos_ff;
            ins_id_in = id_ff;
            ins_per_in = per_w;
            case (op_ff)
               OP_ADD: begin
                  add_b = fd_ff[31] ? per_w : fd_w;
                  ins_next_in = add_sat;
                  ptr_in = '0;
                  if (per_in_ff == 32'd0) status_in = ST_BAD_PER;
                  else if (found_ff) status_in = ST_DUP;
                  else if (count_ff >= CNT_BITS'(MAX_TIMERS)) status_in = ST_FULL;
               end
               OP_REMOVE: if (!found_ff) status_in = ST_NOTFOUND;
               OP_RUN: begin
                  if (!found_ff) status_in = ST_NOTFOUND;
                  ins_per_in = tab_per[pos_ff[IDX_BITS-1:0]];
                  add_b = tab_per[pos_ff[IDX_BITS-1:0]];
                  ins_next_in = add_sat;
               end
               OP_UPDATE: begin
                  if (per_in_ff == 32'd0) status_in = ST_BAD_PER;
                  else if (!found_ff) status_in = ST_NOTFOUND;
                  ins_next_in = rst_ff ? add_sat : tab_next[pos_ff[IDX_BITS-1:0]];
               end
               OP_CLEAR: count_in = '0;
               default: ;
            endcase
            if (op_ff == OP_SERVICE || op_ff == OP_CLEAR || op_ff == OP_QUERY ||
                op_ff == OP_UNUSED)
               ptr_in = '0;
         end
         S_TAKE: begin
            if (ptr_ff + CNT_BITS'(1) >= count_ff) begin
               count_in = count_ff - CNT_BITS'(1);
               ptr_in = '0;
            end else begin
               ptr_in = ptr_ff + CNT_BITS'(1);
            end
         end
         S_INS_SCAN: begin
            if (ptr_ff >= count_ff || ins_next_ff < tab_next[pidx] ||
                (ins_next_ff == tab_next[pidx] && ins_id_ff < tab_id[pidx])) begin
               pos_in = ptr_ff;
               ptr_in = count_ff;
            end else begin
               ptr_in = ptr_ff + CNT_BITS'(1);
            end
         end
         S_INS_SHIFT: begin
            if (ptr_ff == pos_ff) begin
               count_in = count_ff + CNT_BITS'(1);
               ptr_in = '0;
            end else begin
               ptr_in = ptr_ff - CNT_BITS'(1);
            end
         end
         S_SVC_CHECK: begin
            ptr_in = '0;
            ins_id_in = tab_id[0];
            ins_per_in = tab_per[0];
            add_b = tab_per[0];
            ins_next_in = add_sat;
            pos_in = '0;
            after_ins_svc_in = 1'b1;
         end
         S_FIRE_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               rsp_in.fired_id = 8'(ins_id_ff);
               rsp_in.fire_time = 32'(now_ff);
               rsp_in.is_registered = 1'b1;
               fired_in = fired_ff + FC_BITS'(1);
               ptr_in = (op_ff == OP_ADD) ? '0 : pos_ff;
            end
         end
         S_STAT_FIND: begin
            if (ptr_ff < count_ff && tab_id[pidx] != id_ff)
               ptr_in = ptr_ff + CNT_BITS'(1);
         end
         S_STAT_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.kind = 1'b1;
               rsp_in.fired_id = 8'(id_ff);
               rsp_in.fire_time = '0;
               rsp_in.status = status_ff;
               rsp_in.is_registered = (ptr_ff < count_ff);
               rsp_in.active_count = 5'(count_ff);
               rsp_in.due_pending = (count_ff != '0) && (tab_next[0] <= now_ff);
               rsp_in.fired_count = 5'(fired_ff);
               rsp_in.last = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Table moves: shift down on take-out, shift up then write on insert.
   always_ff @(posedge clock) begin
      if (state_ff == S_TAKE && ptr_ff + CNT_BITS'(1) < count_ff) begin
         tab_id[pidx]   <= tab_id[IDX_BITS'(ptr_ff + CNT_BITS'(1))];
         tab_per[pidx]  <= tab_per[IDX_BITS'(ptr_ff + CNT_BITS'(1))];
         tab_next[pidx] <= tab_next[IDX_BITS'(ptr_ff + CNT_BITS'(1))];
      end else if (state_ff == S_INS_SHIFT) begin
         if (ptr_ff == pos_ff) begin
            tab_id[pidx]   <= ins_id_ff;
            tab_per[pidx]  <= ins_per_ff;
            tab_next[pidx] <= ins_next_ff;
         end else begin
            tab_id[pidx]   <= tab_id[pidx_m1];
            tab_per[pidx]  <= tab_per[pidx_m1];
            tab_next[pidx] <= tab_next[pidx_m1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff           <= ptr_in;
      pos_ff           <= pos_in;
      found_ff         <= found_in;
      fired_ff         <= fired_in;
      status_ff        <= status_in;
      ins_id_ff        <= ins_id_in;
      ins_per_ff       <= ins_per_in;
      ins_next_ff      <= ins_next_in;
      after_ins_svc_ff <= after_ins_svc_in;
      rsp_ff           <= rsp_in;
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_TIMERS))
      else $error("timer count beyond table size");
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("request taken while busy");
   a_fire_cap: assert property (@(posedge clock) disable iff (reset)
      fired_ff <= FC_BITS'(MAX_TIMERS))
      else $error("fire count beyond cap");
`endif

endmodule
